// ===== sv/wlt_pkg.sv =====
// Types and codes shared by the worker liveness table.
// Holds the scan token carried along the cell chain and the write-back command sent to every cell.
package wlt_pkg;

  typedef enum logic [1:0] {
    CMD_REGISTER  = 2'd0,
    CMD_HEARTBEAT = 2'd1,
    CMD_MARK_DEAD = 2'd2,
    CMD_FIND      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RS_OK        = 3'd0,
    RS_INVALID   = 3'd1,
    RS_ALREADY   = 3'd2,
    RS_FULL      = 3'd3,
    RS_EXHAUSTED = 3'd4,
    RS_NOT_FOUND = 3'd5,
    RS_NOT_ALIVE = 3'd6,
    RS_MISMATCH  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    SLOT_UNUSED = 2'd0,
    SLOT_ALIVE  = 2'd1,
    SLOT_DEAD   = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    WR_REG  = 2'd0,
    WR_HB   = 2'd1,
    WR_KILL = 2'd2
  } wr_op_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_FIN  = 2'd2
  } fsm_t;

  localparam logic [15:0] CONN_NONE = 16'hFFFF;
  localparam logic [31:0] ID_FIRST  = 32'd1;

  // Request plus what the cells upstream have found so far.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] id;
    logic [15:0] conn;
    logic [63:0] now;
    logic        hit;
    logic        hit_alive;
    logic [15:0] hit_conn;
    logic [62:0] hit_hb;
    logic        dup;
    logic        free;
  } scan_tok_t;

  typedef struct packed {
    logic        en;
    wr_op_t      op;
    logic [31:0] id;
    logic [15:0] conn;
    logic [62:0] hb;
  } wr_t;

endpackage

// ===== sv/worker_liveness_table.sv =====
// Worker liveness table: WORKERS slots, each a cell in a chain that a request token walks
// one slot per cycle; the finish step then resolves the result and does the write-back.
// A transaction passes the token stage of every cell, then the finish register and the
// finish step, before the next one can be accepted; the finish step loads the result.
// The result register lets a new transaction start while the previous result still waits
// on out_stall, but the finish step holds, and with it the next accept, for as long as
// that earlier result is still held.
module worker_liveness_table #(
  parameter int WORKERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [31:0]        in_worker_id,
  input  logic signed [15:0] in_conn,
  input  logic signed [63:0] in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [31:0]        out_assigned_id,
  output logic               out_found,
  output logic               out_found_alive,
  output logic signed [15:0] out_found_conn,
  output logic [62:0]        out_found_heartbeat
);

  wlt_pkg::fsm_t      state_r, state_nxt;
  wlt_pkg::scan_tok_t tok_in;
  wlt_pkg::scan_tok_t tok_a [0:WORKERS];
  logic [WORKERS:0]   vld_a;
  wlt_pkg::scan_tok_t fin_r;
  logic [31:0]        next_id_r;
  wlt_pkg::wr_t       wr;

  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [31:0]        out_assigned_r;
  logic               out_found_r;
  logic               out_alive_r;
  logic [15:0]        out_conn_r;
  logic [62:0]        out_hb_r;

  wlt_pkg::status_t   res_status;
  logic               res_write;
  wlt_pkg::wr_op_t    res_op;
  logic               res_found;
  logic               fin_load;
  logic               out_load;
  logic               accept;

  assign in_stall = (state_r != wlt_pkg::FSM_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    tok_in           = '0;
    tok_in.cmd       = wlt_pkg::cmd_t'(in_cmd);
    tok_in.id        = in_worker_id;
    tok_in.conn      = in_conn;
    tok_in.now       = in_now_ms;
  end

  assign tok_a[0] = tok_in;
  assign vld_a[0] = accept;

  for (genvar g = 0; g < WORKERS; g++) begin : g_cell
    wlt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok_a[g]),
      .vld_i (vld_a[g]),
      .wr_i  (wr),
      .tok_o (tok_a[g+1]),
      .vld_o (vld_a[g+1])
    );
  end

  // Resolve the finished scan into a status, a write-back and, for a find, the found result.
  always_comb begin
    res_status = wlt_pkg::RS_OK;
    res_write  = 1'b0;
    res_op     = wlt_pkg::WR_REG;
    res_found  = 1'b0;
    case (fin_r.cmd)
      wlt_pkg::CMD_REGISTER: begin
        res_op = wlt_pkg::WR_REG;
        if (fin_r.conn[15] || fin_r.now[63]) begin
          res_status = wlt_pkg::RS_INVALID;
        end else if (fin_r.dup) begin
          res_status = wlt_pkg::RS_ALREADY;
        end else if (!fin_r.free) begin
          res_status = wlt_pkg::RS_FULL;
        end else if (next_id_r == '0) begin
          res_status = wlt_pkg::RS_EXHAUSTED;
        end else begin
          res_write = 1'b1;
        end
      end
      wlt_pkg::CMD_HEARTBEAT: begin
        res_op = wlt_pkg::WR_HB;
        if (fin_r.now[63] || fin_r.conn[15]) begin
          res_status = wlt_pkg::RS_INVALID;
        end else if (!fin_r.hit) begin
          res_status = wlt_pkg::RS_NOT_FOUND;
        end else if (!fin_r.hit_alive) begin
          res_status = wlt_pkg::RS_NOT_ALIVE;
        end else if (fin_r.hit_conn != fin_r.conn) begin
          res_status = wlt_pkg::RS_MISMATCH;
        end else if (fin_r.now[62:0] < fin_r.hit_hb) begin
          res_status = wlt_pkg::RS_INVALID;
        end else begin
          res_write = 1'b1;
        end
      end
      wlt_pkg::CMD_MARK_DEAD: begin
        res_op = wlt_pkg::WR_KILL;
        if (fin_r.conn[15]) begin
          res_status = wlt_pkg::RS_INVALID;
        end else if (!fin_r.hit) begin
          res_status = wlt_pkg::RS_NOT_FOUND;
        end else if (!fin_r.hit_alive) begin
          res_status = wlt_pkg::RS_NOT_ALIVE;
        end else if (fin_r.hit_conn != fin_r.conn) begin
          res_status = wlt_pkg::RS_MISMATCH;
        end else begin
          res_write = 1'b1;
        end
      end
      wlt_pkg::CMD_FIND: begin
        // An id of zero is never located.
        if (fin_r.hit && (fin_r.id != '0)) begin
          res_found = 1'b1;
        end else begin
          res_status = wlt_pkg::RS_NOT_FOUND;
        end
      end
      default: begin
        res_status = wlt_pkg::RS_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    fin_load  = 1'b0;
    out_load  = 1'b0;
    wr        = '0;
    wr.op     = res_op;
    wr.id     = next_id_r;
    wr.conn   = fin_r.conn;
    wr.hb     = fin_r.now[62:0];
    case (state_r)
      wlt_pkg::FSM_IDLE: begin
        if (in_valid) begin
          state_nxt = wlt_pkg::FSM_SCAN;
        end
      end
      wlt_pkg::FSM_SCAN: begin
        if (vld_a[WORKERS]) begin
          fin_load  = 1'b1;
          state_nxt = wlt_pkg::FSM_FIN;
        end
      end
      wlt_pkg::FSM_FIN: begin
        // Hold until the result register is free.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          wr.en     = res_write;
          state_nxt = wlt_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = wlt_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wlt_pkg::FSM_IDLE;
      next_id_r   <= wlt_pkg::ID_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr.en && (wr.op == wlt_pkg::WR_REG)) begin
        next_id_r <= next_id_r + 32'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin_r <= tok_a[WORKERS];
    end
    if (out_load) begin
      out_status_r   <= res_status;
      out_assigned_r <= (res_write && (res_op == wlt_pkg::WR_REG)) ? next_id_r : '0;
      out_found_r    <= res_found;
      out_alive_r    <= res_found ? fin_r.hit_alive : 1'b0;
      out_conn_r     <= res_found ? fin_r.hit_conn : '0;
      out_hb_r       <= res_found ? fin_r.hit_hb : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_assigned_id     = out_assigned_r;
  assign out_found           = out_found_r;
  assign out_found_alive     = out_alive_r;
  assign out_found_conn      = out_conn_r;
  assign out_found_heartbeat = out_hb_r;

`ifndef SYNTH
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld_a))
    else $error("more than one transaction in the cell chain");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    vld_a[WORKERS] |-> (state_r == wlt_pkg::FSM_SCAN))
    else $error("token left the chain outside a scan");

  a_wr_fin: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == wlt_pkg::FSM_FIN) && out_load)
    else $error("write-back outside the finish step");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == wlt_pkg::FSM_FIN))
    else $error("result shown without a finished scan");

  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(next_id_r) |-> $past(wr.en && (wr.op == wlt_pkg::WR_REG)))
    else $error("id counter moved without a successful register");
`endif

endmodule

// ===== sv/wlt_cell.sv =====
// One slot of the worker liveness table: slot registers plus one token stage.
// Depends on wlt_pkg for the token and write-back types.
module wlt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  wlt_pkg::scan_tok_t tok_i,
  input  logic               vld_i,
  input  wlt_pkg::wr_t       wr_i,
  output wlt_pkg::scan_tok_t tok_o,
  output logic               vld_o
);

  wlt_pkg::slot_state_t state_r, state_nxt;
  logic [31:0]          id_r, id_nxt;
  logic [15:0]          conn_r, conn_nxt;
  logic [62:0]          hb_r, hb_nxt;
  logic                 hit_sel_r, hit_sel_nxt;
  logic                 free_sel_r, free_sel_nxt;
  wlt_pkg::scan_tok_t   tok_r, tok_nxt;
  logic                 vld_r;

  logic used;
  logic alive;
  logic take_hit;
  logic take_free;

  always_comb begin
    used      = (state_r != wlt_pkg::SLOT_UNUSED);
    alive     = (state_r == wlt_pkg::SLOT_ALIVE);
    take_hit  = !tok_i.hit && used && (id_r == tok_i.id);
    take_free = !tok_i.free && !alive;

    tok_nxt      = tok_i;
    tok_nxt.dup  = tok_i.dup | (alive && (conn_r == tok_i.conn));
    tok_nxt.free = tok_i.free | take_free;
    if (take_hit) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.hit_alive = alive;
      tok_nxt.hit_conn  = conn_r;
      tok_nxt.hit_hb    = hb_r;
    end

    // Remember which slot this scan chose; write-back follows the scan.
    hit_sel_nxt  = vld_i ? take_hit : hit_sel_r;
    free_sel_nxt = vld_i ? take_free : free_sel_r;

    state_nxt = state_r;
    id_nxt    = id_r;
    conn_nxt  = conn_r;
    hb_nxt    = hb_r;
    if (wr_i.en) begin
      case (wr_i.op)
        wlt_pkg::WR_REG: begin
          if (free_sel_r) begin
            state_nxt = wlt_pkg::SLOT_ALIVE;
            id_nxt    = wr_i.id;
            conn_nxt  = wr_i.conn;
            hb_nxt    = wr_i.hb;
          end
        end
        wlt_pkg::WR_HB: begin
          if (hit_sel_r) begin
            hb_nxt = wr_i.hb;
          end
        end
        wlt_pkg::WR_KILL: begin
          if (hit_sel_r) begin
            state_nxt = wlt_pkg::SLOT_DEAD;
            conn_nxt  = wlt_pkg::CONN_NONE;
          end
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= wlt_pkg::SLOT_UNUSED;
      id_r       <= '0;
      conn_r     <= wlt_pkg::CONN_NONE;
      hb_r       <= '0;
      hit_sel_r  <= 1'b0;
      free_sel_r <= 1'b0;
      vld_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      id_r       <= id_nxt;
      conn_r     <= conn_nxt;
      hb_r       <= hb_nxt;
      hit_sel_r  <= hit_sel_nxt;
      free_sel_r <= free_sel_nxt;
      vld_r      <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_o = tok_r;
  assign vld_o = vld_r;

endmodule
